// ===== hw/rtl/tpbpc_pkg.sv =====
package tpbpc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int PROM_DEPTH  = 512;
    localparam int PROM_AW     = $clog2(PROM_DEPTH);
    localparam int PIX_PER_ITEM = 4;
    localparam logic [1:0] LAST_PIX_IDX = 2'd3;
    localparam int APB_AW      = 5;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_LOAD  = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        REG_PALETTE_A  = 3'd0,
        REG_PALETTE_B  = 3'd1,
        REG_FLIP_VIEW  = 3'd2,
        REG_BOARD_MODE = 3'd3,
        REG_CLIP_X_MIN = 3'd4,
        REG_CLIP_X_MAX = 3'd5,
        REG_CLIP_Y_MIN = 3'd6,
        REG_CLIP_Y_MAX = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [4:0] palette_a;
        logic [4:0] palette_b;
        logic       flip_view;
        logic       board_mode;
        logic [7:0] clip_x_min;
        logic [7:0] clip_x_max;
        logic [7:0] clip_y_min;
        logic [7:0] clip_y_max;
    } cfg_t;

    // one queued item, already classified and clip-checked
    typedef struct packed {
        kind_t      kind;
        logic [7:0] y;
        logic [5:0] x_hi;
        logic [3:0] keep;
        logic [7:0] plane_one;
        logic [7:0] plane_two;
        logic [8:0] prom_address;
        logic [2:0] prom_word;
    } entry_t;

endpackage

// ===== hw/rtl/tpbpc_regs.sv =====
module tpbpc_regs
    import tpbpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_PALETTE_A:  cfg_next.palette_a  = pwdata[4:0];
                REG_PALETTE_B:  cfg_next.palette_b  = pwdata[4:0];
                REG_FLIP_VIEW:  cfg_next.flip_view  = pwdata[0];
                REG_BOARD_MODE: cfg_next.board_mode = pwdata[0];
                REG_CLIP_X_MIN: cfg_next.clip_x_min = pwdata[7:0];
                REG_CLIP_X_MAX: cfg_next.clip_x_max = pwdata[7:0];
                REG_CLIP_Y_MIN: cfg_next.clip_y_min = pwdata[7:0];
                REG_CLIP_Y_MAX: cfg_next.clip_y_max = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PALETTE_A:  prdata = {27'd0, cfg_reg.palette_a};
            REG_PALETTE_B:  prdata = {27'd0, cfg_reg.palette_b};
            REG_FLIP_VIEW:  prdata = {31'd0, cfg_reg.flip_view};
            REG_BOARD_MODE: prdata = {31'd0, cfg_reg.board_mode};
            REG_CLIP_X_MIN: prdata = {24'd0, cfg_reg.clip_x_min};
            REG_CLIP_X_MAX: prdata = {24'd0, cfg_reg.clip_x_max};
            REG_CLIP_Y_MIN: prdata = {24'd0, cfg_reg.clip_y_min};
            REG_CLIP_Y_MAX: prdata = {24'd0, cfg_reg.clip_y_max};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg            <= '0;
            cfg_reg.clip_x_max <= 8'hff;
            cfg_reg.clip_y_max <= 8'hff;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/tpbpc_front.sv =====
module tpbpc_front
    import tpbpc_pkg::*;
(
    input  cfg_t        cfg,
    input  logic        kind,
    input  logic [13:0] byte_offset,
    input  logic [7:0]  plane_one_byte,
    input  logic [7:0]  plane_two_byte,
    input  logic [8:0]  prom_address,
    input  logic [2:0]  prom_word,
    output entry_t      entry
);

    // screen position and clip mask per pixel
    always_comb
    begin
        logic [7:0] y;
        logic [5:0] x_hi;
        logic [7:0] x;
        logic       y_ok;
        y    = byte_offset[13:6] ^ {8{cfg.flip_view}};
        x_hi = byte_offset[5:0] ^ {6{cfg.flip_view}};
        y_ok = (y >= cfg.clip_y_min) && (y <= cfg.clip_y_max);
        entry.kind         = kind_t'(kind);
        entry.y            = y;
        entry.x_hi         = x_hi;
        entry.plane_one    = plane_one_byte;
        entry.plane_two    = plane_two_byte;
        entry.prom_address = prom_address;
        entry.prom_word    = prom_word;
        for (int j = 0; j < PIX_PER_ITEM; j++)
        begin
            x = {x_hi, 2'(j) ^ {2{cfg.flip_view}}};
            entry.keep[j] = y_ok && (x >= cfg.clip_x_min) && (x <= cfg.clip_x_max);
        end
    end

endmodule

// ===== hw/rtl/tpbpc_queue.sv =====
module tpbpc_queue
    import tpbpc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{QUEUE_AW{1'b0}}, push} - {{QUEUE_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");

endmodule

// ===== hw/rtl/tpbpc_back.sv =====
module tpbpc_back
    import tpbpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       head_valid,
    input  entry_t     head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] pixel_x,
    output logic [7:0] pixel_y,
    output logic [2:0] pixel_color,
    output logic       last_pixel
);

    logic [2:0] prom_mem [PROM_DEPTH];

    logic [1:0] pix_idx_reg;
    logic [1:0] pix_idx_next;
    logic       v1_reg;
    logic       v1_next;
    logic [7:0] x1_reg;
    logic [7:0] y1_reg;
    logic       last1_reg;
    logic [2:0] rd1_reg;
    logic [2:0] rd2_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_x_reg;
    logic [7:0] out_y_reg;
    logic [2:0] out_color_reg;
    logic       out_last_reg;

    logic               out_load;
    logic               en1;
    logic               is_pix;
    logic               is_load;
    logic               lo1;
    logic               hi1;
    logic               lo2;
    logic               hi2;
    logic [7:0]         a1;
    logic [7:0]         a2;
    logic [PROM_AW-1:0] rd_addr1;
    logic [PROM_AW-1:0] rd_addr2;
    logic [7:0]         cur_x;
    logic               cur_keep;
    logic               cur_last;
    logic [3:0]         later_mask;

    assign out_load = !out_valid_reg || out_ready;
    assign en1      = !v1_reg || out_load;
    assign is_pix   = head_valid && (head.kind == KIND_PIXEL);
    assign is_load  = head_valid && (head.kind == KIND_LOAD);
    assign pop      = is_load || (is_pix && en1 && (pix_idx_reg == LAST_PIX_IDX));

    always_comb
    begin
        lo1 = head.plane_one[{1'b0, pix_idx_reg}];
        hi1 = head.plane_one[{1'b1, pix_idx_reg}];
        lo2 = head.plane_two[{1'b0, pix_idx_reg}];
        hi2 = head.plane_two[{1'b1, pix_idx_reg}];
        if (!cfg.board_mode)
        begin
            a1 = {cfg.palette_a[1], cfg.palette_a, hi1, lo1};
            a2 = {cfg.palette_b[1], cfg.palette_b, hi2, lo2};
        end
        else
        begin
            a1 = {1'b0, cfg.palette_a, hi1, lo1};
            a2 = {lo1 | hi1, cfg.palette_b, hi2, lo2};
        end
        rd_addr1   = {1'b0, a1};
        rd_addr2   = {1'b1, a2};
        cur_x      = {head.x_hi, pix_idx_reg ^ {2{cfg.flip_view}}};
        cur_keep   = head.keep[pix_idx_reg];
        later_mask = 4'b1110 << pix_idx_reg;
        cur_last   = ~|(head.keep & later_mask);
    end

    always_comb
    begin
        pix_idx_next   = pix_idx_reg;
        v1_next        = v1_reg;
        out_valid_next = out_valid_reg;
        if (is_pix && en1)
        begin
            pix_idx_next = pix_idx_reg + 1'b1;
        end
        if (en1)
        begin
            v1_next = is_pix && cur_keep;
        end
        if (out_load)
        begin
            out_valid_next = v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            prom_mem[head.prom_address] <= head.prom_word;
        end
        if (en1)
        begin
            rd1_reg <= prom_mem[rd_addr1];
            rd2_reg <= prom_mem[rd_addr2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg    <= cur_x;
            y1_reg    <= head.y;
            last1_reg <= cur_last;
        end
        if (out_load)
        begin
            out_x_reg     <= x1_reg;
            out_y_reg     <= y1_reg;
            out_color_reg <= rd1_reg | rd2_reg;
            out_last_reg  <= last1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_idx_reg   <= '0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pix_idx_reg   <= pix_idx_next;
            v1_reg        <= v1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign last_pixel  = out_last_reg;

    a_idx_on_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_idx_reg != 2'd0) |-> is_pix)
        else $error("pixel index advanced without a pixel item at head");

    a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !out_load) |=> (v1_reg && $stable(rd1_reg) && $stable(rd2_reg)))
        else $error("stalled color read data changed");

endmodule

// ===== hw/rtl/two_plane_bitmap_pixel_colorizer.sv =====
// Two-plane bitmap colorizer.
// Input channel (in_valid/in_ready): a pixel item carries a video offset and
// one byte from each plane; a load item writes one 3-bit color PROM word.
// Output channel (out_valid/out_ready): up to four pixels per pixel item, in
// pixel order, with last_pixel on the last one emitted. Clipped pixels are
// dropped; an item with every pixel clipped gives nothing.
// Items pass a 4-entry queue; the back end walks one pixel per cycle unless
// stalled, so a pixel item holds it until all four pixels are walked. The
// PROM read port pair sets this rate. The user must write configuration over
// the APB port only while no item is in flight; the block does not check it.
// Reset empties the queue and pipeline and restores register defaults; PROM
// contents are undefined until loaded.
// When the receiver stalls, the output register holds and the pixel walk
// stops once stage 1 holds a pixel; in_ready drops when the queue fills.
module two_plane_bitmap_pixel_colorizer
    import tpbpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [13:0]       byte_offset,
    input  logic [7:0]        plane_one_byte,
    input  logic [7:0]        plane_two_byte,
    input  logic [8:0]        prom_address,
    input  logic [2:0]        prom_word,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        pixel_x,
    output logic [7:0]        pixel_y,
    output logic [2:0]        pixel_color,
    output logic              last_pixel,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t   cfg;
    entry_t front_entry;
    entry_t head;
    logic   full;
    logic   head_valid;
    logic   pop;
    logic   push;

    assign in_ready = !full;
    assign push     = in_valid && !full;

    tpbpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpbpc_front u_front (
        .cfg            (cfg),
        .kind           (kind),
        .byte_offset    (byte_offset),
        .plane_one_byte (plane_one_byte),
        .plane_two_byte (plane_two_byte),
        .prom_address   (prom_address),
        .prom_word      (prom_word),
        .entry          (front_entry)
    );

    tpbpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tpbpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule

// ===== tb/two_plane_bitmap_pixel_colorizer_checker.sv =====
`timescale 1ns / 100ps

module two_plane_bitmap_pixel_colorizer_checker
    import tpbpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              kind,
    input  logic [13:0]       byte_offset,
    input  logic [7:0]        plane_one_byte,
    input  logic [7:0]        plane_two_byte,
    input  logic [8:0]        prom_address,
    input  logic [2:0]        prom_word,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [7:0]        pixel_x,
    input  logic [7:0]        pixel_y,
    input  logic [2:0]        pixel_color,
    input  logic              last_pixel,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending,
    output int                pixels_checked
);

    typedef struct {
        logic [7:0] x;
        logic [7:0] y;
        logic [2:0] color;
        logic       last;
    } pixel_t;

    pixel_t     expected_pixels[$];
    logic [2:0] color_rom [PROM_DEPTH];
    cfg_t       view;

    initial
    begin
        fail_count     = 0;
        pending        = 0;
        pixels_checked = 0;
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic void colorize_item(logic [13:0] ofs, logic [7:0] p1, logic [7:0] p2);
        pixel_t     px;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] col;
        logic [7:0] row;
        logic       lo1;
        logic       hi1;
        logic       lo2;
        logic       hi2;
        int         first;
        first = expected_pixels.size();
        for (int i = 0; i < PIX_PER_ITEM; i++)
        begin
            lo1 = p1[i];
            hi1 = p1[i + 4];
            lo2 = p2[i];
            hi2 = p2[i + 4];
            a1  = {1'b0, view.palette_a, hi1, lo1};
            a2  = {1'b0, view.palette_b, hi2, lo2};
            if (!view.board_mode)
            begin
                a1[7] = view.palette_a[1];
                a2[7] = view.palette_b[1];
            end
            else
            begin
                a2[7] = lo1 | hi1;
            end
            col = {ofs[5:0], 2'b00} + 8'(i);
            row = ofs[13:6];
            if (view.flip_view)
            begin
                col = ~col;
                row = ~row;
            end
            if (col >= view.clip_x_min && col <= view.clip_x_max &&
                row >= view.clip_y_min && row <= view.clip_y_max)
            begin
                px.x     = col;
                px.y     = row;
                px.color = color_rom[{1'b0, a1}] | color_rom[{1'b1, a2}];
                px.last  = 1'b0;
                expected_pixels.push_back(px);
            end
        end
        if (expected_pixels.size() > first)
            expected_pixels[expected_pixels.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_t want;
        if (!rst_n)
        begin
            view            = '0;
            view.clip_x_max = 8'hff;
            view.clip_y_max = 8'hff;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("pixel x=%0d y=%0d with nothing expected",
                                              pixel_x, pixel_y));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (pixel_x !== want.x)
                        report_mismatch($sformatf("pixel_x got %0d want %0d", pixel_x, want.x));
                    if (pixel_y !== want.y)
                        report_mismatch($sformatf("pixel_y got %0d want %0d", pixel_y, want.y));
                    if (pixel_color !== want.color)
                        report_mismatch($sformatf("pixel_color got %0d want %0d at x=%0d y=%0d",
                                                  pixel_color, want.color, want.x, want.y));
                    if (last_pixel !== want.last)
                        report_mismatch($sformatf("last_pixel got %0d want %0d at x=%0d y=%0d",
                                                  last_pixel, want.last, want.x, want.y));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_AW-1:2]))
                    REG_PALETTE_A:  view.palette_a  = pwdata[4:0];
                    REG_PALETTE_B:  view.palette_b  = pwdata[4:0];
                    REG_FLIP_VIEW:  view.flip_view  = pwdata[0];
                    REG_BOARD_MODE: view.board_mode = pwdata[0];
                    REG_CLIP_X_MIN: view.clip_x_min = pwdata[7:0];
                    REG_CLIP_X_MAX: view.clip_x_max = pwdata[7:0];
                    REG_CLIP_Y_MIN: view.clip_y_min = pwdata[7:0];
                    REG_CLIP_Y_MAX: view.clip_y_max = pwdata[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (kind == KIND_LOAD)
                    color_rom[prom_address] = prom_word;
                else
                    colorize_item(byte_offset, plane_one_byte, plane_two_byte);
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// ===== tb/tb_two_plane_bitmap_pixel_colorizer.sv =====
`timescale 1ns / 100ps

module tb_two_plane_bitmap_pixel_colorizer;
    import tpbpc_pkg::*;

    // palettes used by the run; their PROM words are loaded before use
    localparam logic [4:0] PALETTES [3] = '{5'd0, 5'd5, 5'd31};

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              kind           = KIND_PIXEL;
    logic [13:0]       byte_offset    = '0;
    logic [7:0]        plane_one_byte = '0;
    logic [7:0]        plane_two_byte = '0;
    logic [8:0]        prom_address   = '0;
    logic [2:0]        prom_word      = '0;
    logic              out_ready      = 1'b0;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [APB_AW-1:0] paddr          = '0;
    logic [31:0]       pwdata         = '0;

    logic              in_ready;
    logic              out_valid;
    logic [7:0]        pixel_x;
    logic [7:0]        pixel_y;
    logic [2:0]        pixel_color;
    logic              last_pixel;
    logic [31:0]       prdata;
    logic              pready;

    logic              tx_steady = 1'b0;
    logic              rx_steady = 1'b0;
    logic              hold_req  = 1'b0;
    int                pixel_items = 0;
    int                load_items  = 0;
    int                settings    = 0;
    int                fail_count;
    int                pending;
    int                pixels_checked;

    always #5 clk = ~clk;

    two_plane_bitmap_pixel_colorizer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .byte_offset    (byte_offset),
        .plane_one_byte (plane_one_byte),
        .plane_two_byte (plane_two_byte),
        .prom_address   (prom_address),
        .prom_word      (prom_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .pixel_color    (pixel_color),
        .last_pixel     (last_pixel),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    two_plane_bitmap_pixel_colorizer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .byte_offset    (byte_offset),
        .plane_one_byte (plane_one_byte),
        .plane_two_byte (plane_two_byte),
        .prom_address   (prom_address),
        .prom_word      (prom_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .pixel_color    (pixel_color),
        .last_pixel     (last_pixel),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending        (pending),
        .pixels_checked (pixels_checked)
    );

    initial
    begin
        #2_000_000;
        $display("timeout with %0d pixels outstanding", pending);
        $display("FAIL");
        $finish;
    end

    // receiver: random stalls (none when rx_steady), or one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (80) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready <= rx_steady || ($urandom_range(99) >= 30);
        end
    end

    task automatic send_item(kind_t k, logic [13:0] ofs, logic [7:0] p1, logic [7:0] p2,
                             logic [8:0] addr, logic [2:0] word);
        in_valid       <= 1'b1;
        kind           <= k;
        byte_offset    <= ofs;
        plane_one_byte <= p1;
        plane_two_byte <= p2;
        prom_address   <= addr;
        prom_word      <= word;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (k == KIND_LOAD)
            load_items++;
        else
            pixel_items++;
        if (!tx_steady && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    task automatic send_pixel(logic [13:0] ofs, logic [7:0] p1, logic [7:0] p2);
        send_item(KIND_PIXEL, ofs, p1, p2, 9'($urandom_range(511)), 3'($urandom_range(7)));
    endtask

    task automatic send_load(logic [8:0] addr, logic [2:0] word);
        send_item(KIND_LOAD, 14'($urandom_range(16383)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), addr, word);
    endtask

    // every word a palette can reach in either board mode
    task automatic load_palette(logic [4:0] p);
        for (int b = 0; b < 2; b++)
        begin
            for (int hl = 0; hl < 4; hl++)
            begin
                if (b == 0 || p[1])
                    send_load({1'b0, 1'(b), p, 2'(hl)}, 3'($urandom_range(7)));
                send_load({1'b1, 1'(b), p, 2'(hl)}, 3'($urandom_range(7)));
            end
        end
    endtask

    task automatic random_item();
        if ($urandom_range(99) < 25)
            send_load(9'($urandom_range(511)), 3'($urandom_range(7)));
        else
            send_pixel(14'($urandom_range(16383)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
    endtask

    // drain: all pixels back, then let queued loads and clipped items retire
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (32) @(negedge clk);
    endtask

    task automatic set_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(logic [4:0] pa, logic [4:0] pb, logic flip, logic mode,
                             logic [7:0] xmin, logic [7:0] xmax,
                             logic [7:0] ymin, logic [7:0] ymax);
        settle();
        set_reg(REG_PALETTE_A, 32'(pa));
        set_reg(REG_PALETTE_B, 32'(pb));
        set_reg(REG_FLIP_VIEW, 32'(flip));
        set_reg(REG_BOARD_MODE, 32'(mode));
        set_reg(REG_CLIP_X_MIN, 32'(xmin));
        set_reg(REG_CLIP_X_MAX, 32'(xmax));
        set_reg(REG_CLIP_Y_MIN, 32'(ymin));
        set_reg(REG_CLIP_Y_MAX, 32'(ymax));
        settings++;
    endtask

    initial
    begin : stimulus
        int         n;
        int         phase;
        logic [7:0] xmin;
        logic [7:0] xmax;
        logic [7:0] ymin;
        logic [7:0] ymax;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // every PROM word a palette in use can reach is loaded before any pixel reads it
        for (n = 0; n < 3; n++)
            load_palette(PALETTES[n]);

        configure(5'd0, 5'd0, 1'b0, 1'b0, 8'd0, 8'd255, 8'd0, 8'd255);
        send_pixel(14'd0, 8'h00, 8'h00);
        send_pixel(14'd16383, 8'hff, 8'hff);
        send_pixel(14'd63, 8'h0f, 8'hf0);
        send_pixel(14'd64, 8'haa, 8'h55);
        send_pixel(14'd8191, 8'h5a, 8'ha5);
        send_load(9'd0, 3'd7);
        send_load(9'd256, 3'd0);
        send_pixel(14'd0, 8'h00, 8'h00);

        configure(5'd31, 5'd31, 1'b1, 1'b0, 8'd0, 8'd255, 8'd0, 8'd255);
        send_pixel(14'd0, 8'hff, 8'h00);
        send_pixel(14'd16383, 8'h33, 8'hcc);

        configure(5'd0, 5'd31, 1'b0, 1'b1, 8'd0, 8'd255, 8'd0, 8'd255);
        send_pixel(14'd100, 8'hf0, 8'h0f);
        send_pixel(14'd200, 8'h00, 8'hff);
        send_pixel(14'd300, 8'h11, 8'h22);

        // narrow window: partial, fully clipped, and clipped by row
        configure(5'd5, 5'd31, 1'b0, 1'b0, 8'd4, 8'd6, 8'd0, 8'd0);
        send_pixel(14'd1, 8'h96, 8'h69);
        send_pixel(14'd0, 8'hff, 8'hff);
        send_pixel(14'd65, 8'hff, 8'hff);

        // inverted window lets nothing through
        configure(5'd31, 5'd5, 1'b0, 1'b1, 8'd200, 8'd100, 8'd0, 8'd255);
        send_pixel(14'd50, 8'h3c, 8'hc3);

        configure(5'd31, 5'd0, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(14'd16383, 8'h77, 8'hee);
        send_pixel(14'd16320, 8'hff, 8'h00);

        for (phase = 0; phase < 4; phase++)
        begin
            if ($urandom_range(3) != 0)
            begin
                xmin = 8'($urandom_range(63));
                xmax = 8'($urandom_range(255, 192));
                ymin = 8'($urandom_range(63));
                ymax = 8'($urandom_range(255, 192));
            end
            else
            begin
                xmin = 8'($urandom_range(255));
                xmax = 8'($urandom_range(255));
                ymin = 8'($urandom_range(255));
                ymax = 8'($urandom_range(255));
            end
            configure(PALETTES[$urandom_range(2)], PALETTES[$urandom_range(2)],
                      1'($urandom_range(1)), 1'($urandom_range(1)), xmin, xmax, ymin, ymax);
            tx_steady = (phase == 1 || phase == 2);
            rx_steady = (phase == 1);
            if (phase == 2)
                hold_req = 1'b1;
            for (n = 0; n < 12; n++)
            begin
                if (phase == 3 && n == 6)
                begin
                    in_valid <= 1'b0;
                    while (pending != 0) @(negedge clk);
                    @(negedge clk);
                end
                random_item();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        settle();

        $display("Sent %0d pixel items and %0d PROM loads over %0d register settings",
                 pixel_items, load_items, settings);
        $display("Checked %0d pixels, including a long output stall and an input drain",
                 pixels_checked);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
